[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

[rtl/core/uidt_pkg.sv]
`timescale 1ns / 1ps
package uidt_pkg;

    localparam int MAX_IDS = 16;
    localparam int ID_W    = 16;
    localparam int OP_W    = 2;
    localparam int IDX_W   = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
    localparam int CNT_W   = $clog2(MAX_IDS + 1);

    localparam logic [OP_W-1:0] OP_CHECK = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;

    typedef struct packed {
        logic            accept;
        logic [OP_W-1:0] op;
        logic            do_add;
        logic            start_search;
        logic            step;
        logic            use_cand;
        logic            load_imm;
        logic            load_search;
    } uidt_cmd_t;

    typedef struct packed {
        logic hit;
        logic last;
    } uidt_status_t;

endpackage

[rtl/core/uidt_dp.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module uidt_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  uidt_pkg::uidt_cmd_t           cmd,
    input  logic [uidt_pkg::ID_W-1:0]     id_value,
    output uidt_pkg::uidt_status_t        sts,
    output logic                          present,
    output logic                          update_flag,
    output logic [uidt_pkg::ID_W-1:0]     next_id
);

    logic [uidt_pkg::ID_W-1:0]  table_reg [uidt_pkg::MAX_IDS];
    logic [uidt_pkg::IDX_W-1:0] wpos_reg, wpos_next;
    logic [uidt_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       flag_reg, flag_next;
    logic [uidt_pkg::ID_W-1:0]  cand_reg;
    logic [uidt_pkg::IDX_W-1:0] step_reg;
    logic                       present_reg;
    logic                       uflag_reg;
    logic [uidt_pkg::ID_W-1:0]  next_reg;
    logic [uidt_pkg::ID_W-1:0]  key;
    logic                       hit;
    logic                       store;

    assign key = cmd.use_cand ? cand_reg : id_value;

    // Parallel compare against the filled part of the ring.
    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < uidt_pkg::MAX_IDS; i++) begin
            if ((uidt_pkg::CNT_W'(i) < count_reg) && (table_reg[i] == key)) begin
                hit = 1'b1;
            end
        end
    end

    assign sts.hit  = hit;
    assign sts.last = (step_reg == uidt_pkg::IDX_W'(uidt_pkg::MAX_IDS - 1));

    assign store = cmd.do_add && !hit;

    always_comb begin
        wpos_next  = wpos_reg;
        count_next = count_reg;
        flag_next  = flag_reg;
        if (cmd.do_add) begin
            flag_next = !hit;
        end
        if (store) begin
            wpos_next = (wpos_reg == uidt_pkg::IDX_W'(uidt_pkg::MAX_IDS - 1)) ?
                        '0 : wpos_reg + 1'b1;
            if (count_reg != uidt_pkg::CNT_W'(uidt_pkg::MAX_IDS)) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg  <= '0;
            count_reg <= '0;
            flag_reg  <= 1'b0;
            step_reg  <= '0;
        end else begin
            wpos_reg  <= wpos_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
            if (cmd.start_search) begin
                step_reg <= '0;
            end else if (cmd.step) begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (store) begin
            table_reg[wpos_reg] <= id_value;
        end
        if (cmd.start_search) begin
            cand_reg <= id_value + 1'b1;
        end else if (cmd.step) begin
            cand_reg <= cand_reg + 1'b1;
        end
        if (cmd.load_imm) begin
            present_reg <= (cmd.op == uidt_pkg::OP_CHECK) && hit;
            uflag_reg   <= flag_next;
            next_reg    <= '0;
        end else if (cmd.load_search) begin
            present_reg <= 1'b0;
            uflag_reg   <= flag_reg;
            next_reg    <= hit ? cand_reg + 1'b1 : cand_reg;
        end
    end

    assign present     = present_reg;
    assign update_flag = uflag_reg;
    assign next_id     = next_reg;

    `ASSERT_CLK(a_count_bound, count_reg <= uidt_pkg::CNT_W'(uidt_pkg::MAX_IDS), "valid count overflow")
    `ASSERT_CLK(a_ring_fill, (count_reg != uidt_pkg::CNT_W'(uidt_pkg::MAX_IDS)) |-> (uidt_pkg::CNT_W'(wpos_reg) == count_reg), "write position out of step with fill")
    `ASSERT_CLK(a_no_step_past_end, cmd.step |-> !sts.last, "search stepped past last candidate")

endmodule

[rtl/core/uidt_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module uidt_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic [uidt_pkg::OP_W-1:0]     s_op,
    output logic                          s_tready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  uidt_pkg::uidt_status_t        sts,
    output uidt_pkg::uidt_cmd_t           cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    logic state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic out_free;
    logic accept;
    logic done;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign done     = !sts.hit || sts.last;

    always_comb begin
        cmd              = '0;
        cmd.accept       = accept;
        cmd.op           = s_op;
        cmd.do_add       = accept && (s_op == uidt_pkg::OP_ADD);
        cmd.start_search = accept && (s_op == uidt_pkg::OP_NEXT);
        cmd.load_imm     = accept && (s_op != uidt_pkg::OP_NEXT);
        cmd.use_cand     = (state_reg == ST_SEARCH);
        cmd.step         = (state_reg == ST_SEARCH) && !done;
        cmd.load_search  = (state_reg == ST_SEARCH) && done && out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.start_search) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (cmd.load_search) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_imm || cmd.load_search) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `ASSERT_CLK(a_result_source, $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_SEARCH || $past(accept)), "result raised without a request")
    `ASSERT_CLK(a_search_blocks, (state_reg == ST_SEARCH) |-> !s_tready, "request taken during search")
    `ASSERT_CLK(a_search_ends, (state_reg == ST_SEARCH && sts.last && out_free) |=> (state_reg == ST_IDLE), "search ran past its last candidate")

endmodule

[rtl/core/used_id_table_with_next_free.sv]
`timescale 1ns / 1ps
// Check and add: the result is registered in the cycle after the request is taken.
// Next-free: the request starts a search of one candidate per cycle against
// the full table compare; the result is registered when the search ends.
// One request at a time: no new one is taken while a search runs or a result waits.
// Reset (aresetn low, synchronous) empties the table, zeroes the ring
// position and the update flag, and drops any pending result.
module used_id_table_with_next_free (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] id_value
    input  logic [1:0]  s_tuser,   // [1:0] op
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] present, [1] update_flag, [17:2] next_id, rest zero
);

    uidt_pkg::uidt_cmd_t          cmd;
    uidt_pkg::uidt_status_t       sts;
    logic                         present;
    logic                         update_flag;
    logic [uidt_pkg::ID_W-1:0]    next_id;

    // Sequencer: takes requests, walks the next-free search, owns the
    // result valid and the backpressure toward the request side.
    uidt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table, ring pointer, fill count, search candidate and result register.
    uidt_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .id_value    (s_tdata),
        .sts         (sts),
        .present     (present),
        .update_flag (update_flag),
        .next_id     (next_id)
    );

    // Pack the result fields from the lowest bit up; pad to whole bytes.
    assign m_tdata = {6'b0, next_id, update_flag, present};

endmodule

[tb/used_id_table_with_next_free_test.sv]
`timescale 1ns / 1ps
module used_id_table_with_next_free_test;

    // Op code outside the named set: the block must leave all state alone.
    localparam logic [uidt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    // Cycles without any handshake before the run is declared hung. The worst
    // honest gap is the long receiver hold-off plus one full search.
    localparam int QUIET_LIMIT   = 4000;
    // Settling wait at the end, longer than one full search.
    localparam int SETTLE_CYCLES = 3 * (uidt_pkg::MAX_IDS + 1);

    typedef struct packed {
        logic                      present;
        logic                      update_flag;
        logic [uidt_pkg::ID_W-1:0] next_id;
    } lookup_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] id_value
    logic [1:0]  s_tuser;   // [1:0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [0] present, [1] update_flag, [17:2] next_id, rest zero

    used_id_table_with_next_free u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the block state. Only entries below id_count are ever
    // compared, so the contents of unwritten slots never matter.
    logic [uidt_pkg::ID_W-1:0]  known_ids [uidt_pkg::MAX_IDS];
    logic [uidt_pkg::IDX_W-1:0] ring_pos;
    logic [uidt_pkg::CNT_W-1:0] id_count;
    logic                       stored_flag;

    lookup_result_t pending_results[$];
    int             mismatch_count;

    // Traffic shaping, owned by the main sequence.
    bit                        idle_on;
    int                        tx_gap_chance;   // 0: no gaps, N: one request in N waits
    int                        rx_hold_cycles;  // nonzero: sink holds off this long once
    logic [uidt_pkg::ID_W-1:0] cluster_base;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic bit id_is_known(input logic [uidt_pkg::ID_W-1:0] id);
        for (int i = 0; i < uidt_pkg::MAX_IDS; i++) begin
            if (i < id_count && known_ids[i] == id)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one request to the shadow state and return the result it causes.
    function automatic lookup_result_t predict_lookup(
            input logic [uidt_pkg::OP_W-1:0] op,
            input logic [uidt_pkg::ID_W-1:0] id);
        lookup_result_t            res;
        logic [uidt_pkg::ID_W-1:0] cand;
        bit                        found;
        res = '0;
        case (op)
            uidt_pkg::OP_CHECK: begin
                res.present = id_is_known(id);
            end
            uidt_pkg::OP_ADD: begin
                if (id_is_known(id)) begin
                    stored_flag = 1'b0;
                end else begin
                    known_ids[ring_pos] = id;
                    ring_pos = (ring_pos == uidt_pkg::IDX_W'(uidt_pkg::MAX_IDS - 1)) ?
                               '0 : ring_pos + 1'b1;
                    if (id_count < uidt_pkg::MAX_IDS)
                        id_count = id_count + 1'b1;
                    stored_flag = 1'b1;
                end
            end
            uidt_pkg::OP_NEXT: begin
                // Walk id+1 .. id+MAX_IDS with 16-bit wrap; if every candidate is
                // taken, report the one just past the window.
                cand  = id;
                found = 1'b0;
                for (int k = 0; k < uidt_pkg::MAX_IDS; k++) begin
                    if (!found) begin
                        cand = cand + 1'b1;
                        found = !id_is_known(cand);
                    end
                end
                res.next_id = found ? cand : cand + 1'b1;
            end
            default: ;
        endcase
        res.update_flag = stored_flag;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request, hold it until taken, then record its expected result.
    task automatic send_request(input logic [uidt_pkg::OP_W-1:0] op,
                                input logic [uidt_pkg::ID_W-1:0] id);
        if (tx_gap_chance != 0 && $urandom_range(1, tx_gap_chance) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= id;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_lookup(op, id));
    endtask

    // Drop valid and hold off until every outstanding result has been seen.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Mostly identifiers packed around a moving base, so adds collide, checks
    // hit and next-free searches run long; some fully random ones cover all bits.
    function automatic logic [uidt_pkg::ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) == 0)
            return uidt_pkg::ID_W'($urandom_range(0, 65535));
        return uidt_pkg::ID_W'(cluster_base + $urandom_range(0, 40));
    endfunction

    function automatic logic [uidt_pkg::OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return uidt_pkg::OP_ADD;
        if (r < 65) return uidt_pkg::OP_CHECK;
        if (r < 95) return uidt_pkg::OP_NEXT;
        return OP_UNUSED;
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall in random bursts; now and then run a calm stretch; honor a long
    // hold-off when the sequence asks for one.
    initial begin : result_sink
        int hold;
        int calm_left;
        m_tready <= 1'b0;
        calm_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_cycles != 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end else if (idle_on && calm_left == 0 && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                if ($urandom_range(0, 7) == 0)
                    calm_left = $urandom_range(20, 80);
            end else if (calm_left != 0) begin
                calm_left--;
            end
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation, field by field.
    always @(posedge aclk) begin : result_check
        lookup_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.present) begin
                    $display("%0t: present expected %0d actual %0d",
                             $time, want.present, m_tdata[0]);
                    mismatch_count++;
                end
                if (m_tdata[1] !== want.update_flag) begin
                    $display("%0t: update_flag expected %0d actual %0d",
                             $time, want.update_flag, m_tdata[1]);
                    mismatch_count++;
                end
                if (m_tdata[17:2] !== want.next_id) begin
                    $display("%0t: next_id expected %h actual %h",
                             $time, want.next_id, m_tdata[17:2]);
                    mismatch_count++;
                end
            end
        end
    end

    // Abort when no handshake happens on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty table: nothing present, searches return id+1 (with wrap), unused op.
    task automatic test_empty_table();
        send_request(uidt_pkg::OP_CHECK, 16'h0000);
        send_request(uidt_pkg::OP_NEXT, 16'h0000);
        send_request(uidt_pkg::OP_NEXT, 16'hFFFF);
        send_request(OP_UNUSED, 16'hA5A5);
    endtask

    // Store the extreme ids, re-add one (flag drops), check, search across wrap.
    task automatic test_add_duplicate();
        send_request(uidt_pkg::OP_ADD, 16'hFFFF);
        send_request(uidt_pkg::OP_ADD, 16'h0000);
        send_request(uidt_pkg::OP_ADD, 16'hFFFF);
        send_request(uidt_pkg::OP_CHECK, 16'hFFFF);
        send_request(uidt_pkg::OP_NEXT, 16'hFFFE);
    endtask

    // Fill the ring so the whole search window is taken, then overwrite the
    // oldest slot and confirm the evicted id is gone.
    task automatic test_full_table();
        for (int i = 1; i < uidt_pkg::MAX_IDS - 1; i++)
            send_request(uidt_pkg::OP_ADD, uidt_pkg::ID_W'(i));
        send_request(uidt_pkg::OP_NEXT, 16'hFFFE);
        send_request(uidt_pkg::OP_ADD, 16'h8000);
        send_request(uidt_pkg::OP_CHECK, 16'hFFFF);
    endtask

    // Random traffic; re-pick the cluster base and the gap rate every 50 requests.
    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 3))
                    0:       cluster_base = 16'hFFF0;
                    1:       cluster_base = 16'h0000;
                    default: cluster_base = uidt_pkg::ID_W'($urandom_range(0, 65535));
                endcase
                tx_gap_chance = (idle_on && $urandom_range(0, 2) != 0) ? 4 : 0;
            end
            send_request(pick_op(), pick_id());
        end
    endtask

    // Hold the receiver off for a long stretch while requests keep coming, so
    // the block backs up and stalls its request side.
    task automatic test_receiver_hold_off();
        tx_gap_chance = 0;
        rx_hold_cycles = 300;
        for (int n = 0; n < 20; n++)
            send_request(pick_op(), pick_id());
    endtask

    // Pause the sender until the block is empty, then resume.
    task automatic test_sender_pause();
        wait_all_results();
        test_random_traffic(40);
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= uidt_pkg::OP_CHECK;
        ring_pos       = '0;
        id_count       = '0;
        stored_flag    = 1'b0;
        mismatch_count = 0;
        idle_on        = 1'b0;
        tx_gap_chance  = 0;
        rx_hold_cycles = 0;
        cluster_base   = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_add_duplicate();
        test_full_table();

        idle_on = 1'b1;
        test_random_traffic(700);
        test_receiver_hold_off();
        test_random_traffic(300);
        test_sender_pause();
        test_random_traffic(400);

        // Final stretch at full rate on both sides.
        idle_on = 1'b0;
        test_random_traffic(250);

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
